// ===== sv/caf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caf_pkg: shared types and constants of the charge adc frame averager
// Item and result layouts, range scale table, sequencer states.
// ----------------------------------------------------------------------------
package caf_pkg;

  localparam int FRAME_W  = 24;
  localparam int LATEST_W = 20;
  localparam int AVG_OUT_W = 28;
  localparam int CUR_W    = 32;
  localparam int HELD_W   = 5;
  localparam int RANGE_W  = 3;
  localparam int K_W      = 28;
  localparam int K_FRAC   = 24;

  localparam logic [CUR_W-1:0] CUR_LIMIT = 32'd2100000000;

  // operation codes carried on the input side
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // classified word handed from front to back
  typedef struct packed {
    logic                      clear;
    logic signed [FRAME_W-1:0] sample;
  } item_t;

  // one result word
  typedef struct packed {
    logic                        out_ok;
    logic        [HELD_W-1:0]    held;
    logic signed [CUR_W-1:0]     cur;
    logic signed [AVG_OUT_W-1:0] avg;
    logic signed [LATEST_W-1:0]  latest;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_CHK,
    ST_DIV,
    ST_MUL,
    ST_SAT,
    ST_DONE
  } st_t;

  // femtoamps per q.8 lsb in q4.24, per measurement range
  function automatic logic [K_W-1:0] range_k(input logic [RANGE_W-1:0] r);
    logic [K_W-1:0] k;
    unique case (r)
      3'd0: k = 28'd256000488;
      3'd1: k = 28'd12725024;
      3'd2: k = 28'd25525049;
      3'd3: k = 28'd38212573;
      3'd4: k = 28'd51100097;
      3'd5: k = 28'd63750122;
      3'd6: k = 28'd76725146;
      default: k = 28'd89687671;
    endcase
    return k;
  endfunction

endpackage

// ===== sv/caf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caf_front: input word classifier
// Accepts frame words, tells clears from conversions and extracts the sample.
// ----------------------------------------------------------------------------
module caf_front #(
  parameter int SAMPLE_BITS = 20
) (
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [caf_pkg::FRAME_W-1:0]    in_tdata,
  input  logic                           in_tuser,
  input  logic                           q_full,
  output logic                           q_push,
  output caf_pkg::item_t                 q_item
);
  import caf_pkg::*;

  logic signed [SAMPLE_BITS-1:0] raw;

  // accept while the queue has room
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // low bits as two's complement, zero for a clear
  assign raw = signed'(in_tdata[SAMPLE_BITS-1:0]);

  always_comb begin
    q_item.clear  = (in_tuser == OP_CLEAR);
    q_item.sample = (in_tuser == OP_CLEAR) ? '0 : FRAME_W'(raw);
  end

endmodule

// ===== sv/caf_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caf_queue: two-entry word queue
// Decouples the input classifier from the averaging sequencer.
// ----------------------------------------------------------------------------
module caf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  caf_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output caf_pkg::item_t head_item
);
  import caf_pkg::*;

  item_t       slot_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        do_push, do_pop;

  assign full      = (cnt_r == 2'd2);
  assign empty     = (cnt_r == 2'd0);
  assign head_item = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== sv/caf_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caf_div: restoring unsigned divider
// One quotient bit per cycle; done pulses when the quotient is ready.
// ----------------------------------------------------------------------------
module caf_div #(
  parameter int DVD_W = 33,
  parameter int DVS_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVS_W:0]   trial;
  logic             fits;

  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign fits  = (trial >= {1'b0, dvs_r});

  // one shift-subtract step per cycle
  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      cnt_nxt  = CNT_W'(DVD_W);
      busy_nxt = 1'b1;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], fits};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== sv/caf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caf_back: averaging sequencer
// Keeps the sample ring, running sum and fill count, divides for the mean,
// scales it to femtoamps and holds the result in an output register.
// ----------------------------------------------------------------------------
module caf_back #(
  parameter int SAMPLE_DEPTH = 16,
  parameter int MIN_HELD     = 8,
  parameter int SAMPLE_BITS  = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [caf_pkg::RANGE_W-1:0]   cfg_wr_data,
  input  logic                          q_empty,
  input  caf_pkg::item_t                q_item,
  output logic                          q_pop,
  output logic                          res_valid,
  input  logic                          res_ready,
  output caf_pkg::res_t                 res
);
  import caf_pkg::*;

  localparam int SLOT_W = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(SAMPLE_DEPTH + 1);
  localparam int SUM_W  = SAMPLE_BITS + SLOT_W + 1;
  localparam int DVD_W  = SUM_W + 8;
  localparam int AVG_W  = SAMPLE_BITS + 9;
  localparam int MAG_W  = AVG_W - 1;
  localparam int PROD_W = MAG_W + K_W;
  localparam int SHF_W  = PROD_W - K_FRAC;

  st_t state_r, state_nxt;

  // ring storage
  logic signed [SAMPLE_BITS-1:0] mem [SAMPLE_DEPTH];
  logic signed [SAMPLE_BITS-1:0] old_r;

  logic [RANGE_W-1:0]     range_r;
  logic [SLOT_W-1:0]      slot_r;
  logic [CNT_W-1:0]       cnt_r;
  logic signed [SUM_W-1:0] sum_r;
  item_t                  item_r;
  logic                   ring_full;
  logic                   hold_ok;

  logic                   neg_r;
  logic [MAG_W-1:0]       mag_r;
  logic signed [AVG_W-1:0] avg_r;
  logic [PROD_W-1:0]      prod_r;
  logic signed [CUR_W-1:0] cur_r;
  logic                   ok_r;

  logic                   out_valid_r;
  res_t                   out_r;

  logic                   do_pop, rd_en, wr_en, div_start, load_out;
  logic                   div_done;
  logic [DVD_W-1:0]       div_q;
  logic [SUM_W-1:0]       sum_mag;
  logic [SHF_W-1:0]       shifted;
  logic [CUR_W-1:0]       cur_mag;

  assign ring_full = (int'(cnt_r) >= SAMPLE_DEPTH);
  assign hold_ok   = (int'(cnt_r) >= MIN_HELD) && (cnt_r != '0);
  assign sum_mag   = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign shifted   = prod_r[PROD_W-1:K_FRAC];
  assign cur_mag   = (64'(shifted) > 64'(CUR_LIMIT)) ? CUR_LIMIT : CUR_W'(shifted);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (!q_empty) state_nxt = q_item.clear ? ST_CHK : ST_UPD;
      ST_UPD:  state_nxt = ST_CHK;
      ST_CHK:  state_nxt = hold_ok ? ST_DIV : ST_DONE;
      ST_DIV:  if (div_done) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_SAT;
      ST_SAT:  state_nxt = ST_DONE;
      ST_DONE: if (!out_valid_r || res_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer strobes
  always_comb begin
    do_pop    = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        do_pop = !q_empty;
        rd_en  = !q_empty && !q_item.clear;
      end
      ST_UPD:  wr_en = 1'b1;
      ST_CHK:  div_start = hold_ok;
      ST_DONE: load_out = !out_valid_r || res_ready;
      default: ;
    endcase
  end

  assign q_pop = do_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ring memory, registered read of the slot about to be replaced
  always_ff @(posedge clk) begin
    if (rd_en) begin
      old_r <= mem[slot_r];
    end
    if (wr_en) begin
      mem[slot_r] <= SAMPLE_BITS'(item_r.sample);
    end
  end

  // ring bookkeeping and range register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_r <= '0;
      slot_r  <= '0;
      cnt_r   <= '0;
      sum_r   <= '0;
    end else if (cfg_wr_en) begin
      range_r <= cfg_wr_data;
      slot_r  <= '0;
      cnt_r   <= '0;
      sum_r   <= '0;
    end else if (do_pop && q_item.clear) begin
      slot_r <= '0;
      cnt_r  <= '0;
      sum_r  <= '0;
    end else if (wr_en) begin
      sum_r  <= sum_r - (ring_full ? SUM_W'(old_r) : '0) + SUM_W'(item_r.sample);
      cnt_r  <= ring_full ? cnt_r : cnt_r + CNT_W'(1);
      slot_r <= (int'(slot_r) == SAMPLE_DEPTH - 1) ? '0 : slot_r + SLOT_W'(1);
    end
  end

  // captured word
  always_ff @(posedge clk) begin
    if (do_pop) begin
      item_r <= q_item;
    end
  end

  caf_div #(
    .DVD_W (DVD_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({sum_mag, 8'd0}),
    .divisor  (cnt_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // mean, scale and saturate
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_CHK: begin
        neg_r <= sum_r[SUM_W-1];
        ok_r  <= hold_ok;
        avg_r <= '0;
        cur_r <= '0;
      end
      ST_DIV: begin
        if (div_done) begin
          mag_r <= div_q[MAG_W-1:0];
          avg_r <= neg_r ? -signed'({1'b0, div_q[MAG_W-1:0]})
                         :  signed'({1'b0, div_q[MAG_W-1:0]});
        end
      end
      ST_MUL: prod_r <= PROD_W'(mag_r) * PROD_W'(range_k(range_r));
      ST_SAT: cur_r  <= neg_r ? -signed'(cur_mag) : signed'(cur_mag);
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (res_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r.latest <= LATEST_W'(item_r.sample);
      out_r.avg    <= AVG_OUT_W'(avg_r);
      out_r.cur    <= cur_r;
      out_r.held   <= HELD_W'(cnt_r);
      out_r.out_ok <= ok_r;
    end
  end

  assign res_valid = out_valid_r;
  assign res       = out_r;

endmodule

// ===== sv/charge_adc_frame_averager.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// charge_adc_frame_averager: moving average of converter samples
// Ring of recent samples with running sum; outputs the latest sample, the
// q.8 mean and a femtoamp current scaled by the selected range.
//
//   channel  dir  tdata bits (low first)                    tuser
//   in       in   frame_bits[23:0]                          operation
//   out      out  latest_sample[19:0], average_q8[47:20],   output_valid
//                 current_fa[79:48], held_count[84:80],
//                 zero pad[87:85]
//   cfg      in   cfg_wr_data = range_select                 -
//
// A frame word with enough samples holds the sequencer for the divide of the
// sum by the fill count, one quotient bit per cycle, then for the multiply
// and saturate steps. A clear word passes IDLE, CHK and DONE; a frame word
// with too few samples passes IDLE, UPD, CHK and DONE.
// A two-word queue takes input words while the sequencer works or a result
// waits in the output register; in_tready drops once both entries are full.
// Reset is synchronous and needs no clearing pass; the ring empties at once.
// ----------------------------------------------------------------------------
module charge_adc_frame_averager #(
  parameter int SAMPLE_DEPTH = 16,
  parameter int MIN_HELD     = 8,
  parameter int SAMPLE_BITS  = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // frame_bits
  input  logic [0:0]  in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // latest_sample, average_q8, current_fa, held_count
  output logic [0:0]  out_tuser,  // output_valid
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data
);
  import caf_pkg::*;

  logic  q_full, q_empty, q_push, q_pop;
  item_t push_item, head_item;
  res_t  res;

  caf_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser[0]),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  caf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head_item (head_item)
  );

  caf_back #(
    .SAMPLE_DEPTH (SAMPLE_DEPTH),
    .MIN_HELD     (MIN_HELD),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_empty     (q_empty),
    .q_item      (head_item),
    .q_pop       (q_pop),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .res         (res)
  );

  // result packing
  assign out_tdata = {3'd0, res.held, res.cur, res.avg, res.latest};
  assign out_tuser = res.out_ok;

endmodule

// ===== sv/caf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caf_checker: port-level checks of the frame averager
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module caf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [87:0] out_tdata,
  input logic [0:0]  out_tuser
);

  localparam logic signed [31:0] LIM = 32'sd2100000000;

  // stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // mean and current are zero when not enough samples are held
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[47:20] == 28'd0 && out_tdata[79:48] == 32'd0)
    else $error("nonzero mean or current without valid flag");

  // an empty ring never reports valid or a nonzero sample
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[84:80] == 5'd0 |-> !out_tuser[0] && out_tdata[19:0] == 20'd0)
    else $error("empty ring with valid flag or sample");

  // current stays inside the saturation limits
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $signed(out_tdata[79:48]) <= LIM && $signed(out_tdata[79:48]) >= -LIM)
    else $error("current beyond saturation limit");

  // no result right after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind charge_adc_frame_averager caf_checker u_caf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
